// ----- src/xsw_pkg.sv -----
// Shared types and constants for the crosspoint switch register block.
package xsw_pkg;

    // Physical size of the part; parameters on the top level may shrink it
    localparam int unsigned MAX_ROWS   = 12;
    localparam int unsigned MAX_COLS   = 8;
    localparam int unsigned ROW_IDX_W  = 4;
    localparam int unsigned COL_IDX_W  = 3;

    // Command byte layout
    localparam logic [7:0] SW_ON_BIT  = 8'h80;
    localparam logic [7:0] COL_FIELD  = 8'h07;

    // Row code boundaries
    localparam logic [3:0] CODE_LO_LAST  = 4'd5;
    localparam logic [3:0] CODE_HI_FIRST = 4'd8;
    localparam logic [3:0] CODE_HI_LAST  = 4'd13;
    localparam logic [3:0] CODE_HI_SHIFT = 4'd2;

    // Readback addresses, one per row in row order
    localparam logic [7:0] RB_ADDR [MAX_ROWS] = '{
        8'h34, 8'h3c, 8'h74, 8'h7c, 8'h35, 8'h3d,
        8'h75, 8'h7d, 8'h36, 8'h3e, 8'h76, 8'h7e
    };

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_RESET = 2'd2
    } t_xsw_func;

    // Control from the command decoder to the switch matrix
    typedef struct packed {
        logic                 sel_en;
        logic [ROW_IDX_W-1:0] sel_row;
        logic                 wr_en;
        logic [ROW_IDX_W-1:0] wr_row;
        logic [COL_IDX_W-1:0] wr_col;
        logic                 wr_on;
        logic                 load;
        logic                 clear;
        logic                 rd;
        logic                 status;
    } t_xsw_ctl;

endpackage

// ----- src/xsw_decode.sv -----
// Command decoder: turns one word into matrix control.
module xsw_decode
    import xsw_pkg::*;
#(
    parameter int unsigned NUM_ROWS = 12,
    parameter int unsigned NUM_COLS = 8
) (
    input  logic [1:0] i_func,
    input  logic [7:0] i_first_byte,
    input  logic [7:0] i_second_byte,
    output t_xsw_ctl   o_ctl
);

    logic                 hit;
    logic [ROW_IDX_W-1:0] hit_row;
    logic [3:0]           code;
    logic [COL_IDX_W-1:0] col;
    logic [ROW_IDX_W-1:0] row;
    logic                 code_ok;
    logic                 size_ok;

    // readback address match, twelve independent compares
    always_comb begin
        hit     = 1'b0;
        hit_row = '0;
        for (int r = 0; r < MAX_ROWS; r++) begin
            if (RB_ADDR[r] == i_first_byte) begin
                hit     = 1'b1;
                hit_row = ROW_IDX_W'(r);
            end
        end
    end

    // row code to physical row: codes 8..13 sit two above rows 6..11
    always_comb begin
        code = i_first_byte[6:3];
        col  = COL_IDX_W'(i_first_byte & COL_FIELD);
        if (code <= CODE_LO_LAST) begin
            row     = code;
            code_ok = 1'b1;
        end else if (code >= CODE_HI_FIRST && code <= CODE_HI_LAST) begin
            row     = code - CODE_HI_SHIFT;
            code_ok = 1'b1;
        end else begin
            row     = '0;
            code_ok = 1'b0;
        end
        size_ok = (row < ROW_IDX_W'(NUM_ROWS))
                  && ({1'b0, col} < (COL_IDX_W + 1)'(NUM_COLS));
    end

    always_comb begin
        o_ctl        = '0;
        o_ctl.wr_row = row;
        o_ctl.wr_col = col;
        o_ctl.wr_on  = |(i_first_byte & SW_ON_BIT);
        o_ctl.sel_row = hit_row;
        unique case (t_xsw_func'(i_func))
            FN_WRITE: begin
                if (hit) begin
                    if (hit_row < ROW_IDX_W'(NUM_ROWS)) begin
                        o_ctl.sel_en = 1'b1;
                    end else begin
                        o_ctl.status = 1'b1;
                    end
                end else if (code_ok && size_ok) begin
                    o_ctl.wr_en = 1'b1;
                    o_ctl.load  = i_second_byte[0];
                end else begin
                    o_ctl.status = 1'b1;
                end
            end
            FN_READ:  o_ctl.rd    = 1'b1;
            FN_RESET: o_ctl.clear = 1'b1;
            default:  ;
        endcase
    end

endmodule

// ----- src/xsw_matrix.sv -----
// Pending and active switch state, row select and row readback.
module xsw_matrix
    import xsw_pkg::*;
#(
    parameter int unsigned NUM_ROWS = 12,
    parameter int unsigned NUM_COLS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_xsw_ctl   i_ctl,
    output logic [7:0] o_read_cols
);

    localparam int unsigned ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int unsigned COL_W = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

    logic [NUM_ROWS-1:0][NUM_COLS-1:0] r_pending, n_pending;
    logic [NUM_ROWS-1:0][NUM_COLS-1:0] r_active,  n_active;
    logic [ROW_IDX_W-1:0]              r_sel_row, n_sel_row;

    always_comb begin
        n_pending = r_pending;
        n_active  = r_active;
        n_sel_row = r_sel_row;
        if (i_en) begin
            if (i_ctl.clear) begin
                n_pending = '0;
                n_active  = '0;
                n_sel_row = '0;
            end else begin
                if (i_ctl.wr_en) begin
                    n_pending[i_ctl.wr_row[ROW_W-1:0]][i_ctl.wr_col[COL_W-1:0]] = i_ctl.wr_on;
                end
                if (i_ctl.load) begin
                    n_active = n_pending;
                end
                if (i_ctl.sel_en) begin
                    n_sel_row = i_ctl.sel_row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_active  <= '0;
            r_sel_row <= '0;
        end else begin
            r_pending <= n_pending;
            r_active  <= n_active;
            r_sel_row <= n_sel_row;
        end
    end

    always_comb begin
        o_read_cols = '0;
        if (i_ctl.rd && (r_sel_row < ROW_IDX_W'(NUM_ROWS))) begin
            o_read_cols[NUM_COLS-1:0] = r_active[r_sel_row[ROW_W-1:0]];
        end
    end

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_ctl.clear |=> r_active == '0 && r_pending == '0 && r_sel_row == '0)
        else $error("switch state not cleared after reset word");

    a_load_copies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_ctl.load && !i_ctl.clear |=> r_active == r_pending)
        else $error("active switches differ from pending after load");

    a_sel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel_row < ROW_IDX_W'(NUM_ROWS))
        else $error("selected row outside the matrix");

endmodule

// ----- src/crosspoint_switch_8x12_regs.sv -----
// Top level of the crosspoint switch register block: stream ports and stages.
//
//  channel | dir | handshake                    | payload
//  --------+-----+------------------------------+-------------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | tuser func, tdata first/second byte
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata read_cols, status, loaded
//
// Every input word gives exactly one result word. A word is taken into an
// input register, decoded and applied to the switch state on the cycle it
// moves into the result register. One word per cycle is sustained while
// m_axis_tready is high, set by the single decode/update stage.
// Reset (i_rst_n low, synchronous) opens every switch and selects row 0.
// A stall on m_axis holds the result register and then the input register;
// s_axis_tready drops only when both are full.
module crosspoint_switch_8x12_regs
    import xsw_pkg::*;
#(
    parameter int unsigned NUM_ROWS = 12,
    parameter int unsigned NUM_COLS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] first_byte, [15:8] second_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] read_cols, [8] status,
                                        // [9] switches_loaded, [15:10] zero
);

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_func;
    logic [7:0] r_in_first;
    logic [7:0] r_in_second;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_cols;
    logic       r_out_status;
    logic       r_out_loaded;

    t_xsw_ctl   ctl;
    logic [7:0] read_cols;
    logic       advance;   // word in the input register moves on this cycle
    logic       in_take;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_func   <= s_axis_tuser;
            r_in_first  <= s_axis_tdata[7:0];
            r_in_second <= s_axis_tdata[15:8];
        end
    end

    xsw_decode #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) u_decode (
        .i_func        (r_in_func),
        .i_first_byte  (r_in_first),
        .i_second_byte (r_in_second),
        .o_ctl         (ctl)
    );

    // state changes only when the word leaves the input register, so every
    // later word sees the effect of all earlier ones
    xsw_matrix #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) u_matrix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_ctl       (ctl),
        .o_read_cols (read_cols)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_cols   <= read_cols;
            r_out_status <= ctl.status;
            r_out_loaded <= ctl.load;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_loaded, r_out_status, r_out_cols};

    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_status && r_out_loaded))
        else $error("result word both rejected and loaded");

    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_first)
                                   && $stable(r_in_second) && $stable(r_in_func))
        else $error("stalled input word lost or changed");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid)
        else $error("result word dropped while stalled");

endmodule

// ----- bench/tb_crosspoint_switch_8x12_regs.sv -----
// Self-checking bench for the crosspoint switch register block.
module tb_crosspoint_switch_8x12_regs;
    import xsw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Part size as built; the bench runs the block at its full size
    localparam int unsigned NUM_ROWS = 12;
    localparam int unsigned NUM_COLS = 8;

    // Unused function code: the block must swallow it and answer all zero
    localparam logic [1:0] FN_SPARE = 2'd3;

    // Command byte layout
    localparam int unsigned SW_ON_POS = 7;
    localparam logic [3:0]  LOW_CODE_LAST  = 4'd5;
    localparam logic [3:0]  HIGH_CODE_FIRST = 4'd8;
    localparam logic [3:0]  HIGH_CODE_LAST  = 4'd13;

    // Row select addresses, row 0 first
    localparam logic [7:0] ROW_SEL_ADDR [12] = '{
        8'h34, 8'h3c, 8'h74, 8'h7c, 8'h35, 8'h3d,
        8'h75, 8'h7d, 8'h36, 8'h3e, 8'h76, 8'h7e
    };

    // Some directed command bytes
    localparam logic [7:0] ROW0_COL0_ON   = 8'h80;   // code 0, column 0
    localparam logic [7:0] ROW11_COL7_ON  = 8'hef;   // code 13, column 7
    localparam logic [7:0] ROW11_COL7_OFF = 8'h6f;
    localparam logic [7:0] ROW0_COL7_ON   = 8'h87;
    localparam logic [7:0] CODE6_PLAIN    = 8'h30;   // reserved codes, not readback
    localparam logic [7:0] CODE7_ON       = 8'hb8;
    localparam logic [7:0] CODE14_PLAIN   = 8'h70;
    localparam logic [7:0] CODE15_ALL     = 8'hff;

    // Run length: far beyond the slowest correct run
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned IDLE_PCT = 38;

    typedef struct packed {
        logic [7:0] read_cols;
        logic       status;
        logic       switches_loaded;
    } t_xsw_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [7:0] first_byte, [15:8] second_byte
    logic [1:0]  s_axis_tuser = '0;   // [1:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [7:0] read_cols, [8] status, [9] switches_loaded

    // Shadow of the switch matrix
    logic [7:0]  pend_cols [NUM_ROWS];
    logic [7:0]  live_cols [NUM_ROWS];
    logic [3:0]  read_row;

    t_xsw_reply  access_replies [$];
    int unsigned idle_pct = IDLE_PCT;
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;
    int unsigned words_taken = 0;
    int unsigned loads_seen = 0;
    int unsigned row_reads = 0;
    int unsigned rejects_seen = 0;
    int unsigned clears_seen = 0;

    crosspoint_switch_8x12_regs #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Open every switch and point the readback at row 0
    function automatic void clear_matrix();
        for (int r = 0; r < NUM_ROWS; r++) begin
            pend_cols[r] = '0;
            live_cols[r] = '0;
        end
        read_row = '0;
    endfunction

    // One bus access against the shadow matrix; returns the reply word it earns
    function automatic t_xsw_reply switch_access(input logic [1:0] func,
                                                 input logic [7:0] first,
                                                 input logic [7:0] second);
        t_xsw_reply  reply;
        int          hit;
        logic [3:0]  code;
        logic [2:0]  col;
        int unsigned row;
        logic        ok;
        reply = '0;
        hit = -1;
        ok = 1'b1;
        row = 0;
        words_taken++;
        case (func)
            FN_WRITE: begin
                for (int r = 0; r < 12; r++) begin
                    if (ROW_SEL_ADDR[r] == first) begin
                        hit = r;
                    end
                end
                if (hit >= 0) begin
                    // readback address: only moves the row pointer
                    if (hit < NUM_ROWS) begin
                        read_row = 4'(hit);
                    end else begin
                        reply.status = 1'b1;
                    end
                end else begin
                    code = first[6:3];
                    col = first[2:0];
                    if (code <= LOW_CODE_LAST) begin
                        row = code;
                    end else if (code >= HIGH_CODE_FIRST && code <= HIGH_CODE_LAST) begin
                        row = code - 2;
                    end else begin
                        ok = 1'b0;
                    end
                    if (ok && (row >= NUM_ROWS || col >= NUM_COLS)) begin
                        ok = 1'b0;
                    end
                    if (!ok) begin
                        reply.status = 1'b1;
                    end else begin
                        pend_cols[row][col] = first[SW_ON_POS];
                        if (second[0]) begin
                            for (int r = 0; r < NUM_ROWS; r++) begin
                                live_cols[r] = pend_cols[r];
                            end
                            reply.switches_loaded = 1'b1;
                        end
                    end
                end
            end
            FN_READ: begin
                row_reads++;
                if (read_row < NUM_ROWS) begin
                    reply.read_cols = live_cols[read_row] & 8'((1 << NUM_COLS) - 1);
                end
            end
            FN_RESET: begin
                clears_seen++;
                clear_matrix();
            end
            default: begin
            end
        endcase
        if (reply.status) begin
            rejects_seen++;
        end
        if (reply.switches_loaded) begin
            loads_seen++;
        end
        return reply;
    endfunction

    // Result side: random back-pressure, same idle rate as the sender
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Check every result word against the oldest reply due, then log any
    // word taken on the input side at this edge. A reply cannot come out
    // on the edge that takes its word, so the order here is safe.
    always @(posedge i_clk) begin
        t_xsw_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (access_replies.size() == 0) begin
                $error("result word %h with no reply due", m_axis_tdata);
                fault_count++;
            end else begin
                want = access_replies.pop_front();
                if (m_axis_tdata[7:0] !== want.read_cols) begin
                    $error("read_cols: expected %h, got %h", want.read_cols,
                           m_axis_tdata[7:0]);
                    fault_count++;
                end
                if (m_axis_tdata[8] !== want.status) begin
                    $error("status: expected %b, got %b", want.status, m_axis_tdata[8]);
                    fault_count++;
                end
                if (m_axis_tdata[9] !== want.switches_loaded) begin
                    $error("switches_loaded: expected %b, got %b", want.switches_loaded,
                           m_axis_tdata[9]);
                    fault_count++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            access_replies.push_back(switch_access(s_axis_tuser, s_axis_tdata[7:0],
                                                   s_axis_tdata[15:8]));
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one word, after a random gap, and hold it until taken.
    // A gap lowers tvalid on its own edge, so tvalid never gets two updates
    // in one step.
    task automatic send_word(input logic [1:0] func, input logic [7:0] first,
                             input logic [7:0] second);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {second, first};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Straight out of reset: everything open, row 0 selected
    task automatic test_after_reset();
        send_word(FN_READ, 8'hff, 8'hff);
        send_word(FN_SPARE, 8'hff, 8'hff);
        send_word(FN_READ, 8'h00, 8'h00);
    endtask

    // Pending versus active: deferred writes stay hidden until a load
    task automatic test_switch_writes();
        send_word(FN_WRITE, ROW0_COL0_ON, 8'h00);        // deferred
        send_word(FN_WRITE, ROW_SEL_ADDR[0], 8'h00);
        send_word(FN_READ, 8'h00, 8'h00);                // still open
        send_word(FN_WRITE, ROW11_COL7_ON, 8'h01);       // loads both
        send_word(FN_READ, 8'h00, 8'h00);
        send_word(FN_WRITE, ROW_SEL_ADDR[NUM_ROWS-1], 8'h00);
        send_word(FN_READ, 8'h00, 8'h00);
        send_word(FN_WRITE, ROW11_COL7_OFF, 8'hfe);      // off, deferred
        send_word(FN_READ, 8'h00, 8'h00);
        send_word(FN_WRITE, ROW0_COL7_ON, 8'hff);        // loads the off too
        send_word(FN_READ, 8'h00, 8'h00);
    endtask

    // Readback select ignores a load request in its second byte
    task automatic test_row_select();
        send_word(FN_WRITE, ROW_SEL_ADDR[0], 8'hff);
        send_word(FN_READ, 8'h00, 8'h00);
    endtask

    // Reserved row codes: flagged, no change, no load
    task automatic test_reserved_codes();
        send_word(FN_WRITE, CODE6_PLAIN, 8'hff);
        send_word(FN_WRITE, CODE7_ON, 8'h01);
        send_word(FN_WRITE, CODE14_PLAIN, 8'hff);
        send_word(FN_WRITE, CODE15_ALL, 8'h01);
    endtask

    // Hardware reset word wipes switches and the row pointer
    task automatic test_hw_reset();
        send_word(FN_RESET, 8'hff, 8'hff);
        send_word(FN_READ, 8'h00, 8'h00);
    endtask

    // Mostly well-formed traffic: valid writes, selects and reads, with a
    // thin layer of raw command bytes, spare codes and reset words
    task automatic test_mixed_traffic(input int unsigned words);
        int unsigned pick;
        int unsigned row;
        logic [3:0]  code;
        logic [7:0]  first;
        logic [7:0]  second;
        for (int unsigned n = 0; n < words; n++) begin
            pick = $urandom_range(99);
            row = $urandom_range(NUM_ROWS - 1);
            second = 8'($urandom);
            second[0] = ($urandom_range(9) < 3);
            if (pick < 55) begin
                code = (row <= 5) ? 4'(row) : 4'(row + 2);
                first = {1'($urandom), code, 3'($urandom_range(NUM_COLS - 1))};
                send_word(FN_WRITE, first, second);
            end else if (pick < 70) begin
                send_word(FN_WRITE, ROW_SEL_ADDR[row], second);
            end else if (pick < 90) begin
                send_word(FN_READ, 8'($urandom), second);
            end else if (pick < 96) begin
                send_word(FN_WRITE, 8'($urandom), 8'($urandom));
            end else if (pick < 99) begin
                send_word(FN_SPARE, 8'($urandom), 8'($urandom));
            end else begin
                send_word(FN_RESET, 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // Same traffic with both sides always ready: one word per cycle
    task automatic test_full_rate(input int unsigned words);
        idle_pct = 0;
        test_mixed_traffic(words);
        idle_pct = IDLE_PCT;
    endtask

    initial begin
        clear_matrix();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_switch_writes();
        test_row_select();
        test_reserved_codes();
        test_hw_reset();
        test_mixed_traffic(500);
        test_full_rate(300);
        test_mixed_traffic(500);

        s_axis_tvalid <= 1'b0;
        while (access_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words taken: %0d loads, %0d row reads, %0d rejected, %0d clears",
                 words_taken, loads_seen, row_reads, rejects_seen, clears_seen);
        $display("stalls on both sides, plus one stretch at full rate; %0d cycles",
                 cycle_count);
        if (fault_count == 0 && access_replies.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
